// ----- hw/rtl/gbd_pkg.sv -----
// ---------------------------------------------------------------------------
// Two-button gesture detector package
// Shared types, codes and reset values for the detector's front and back
// parts and its queue.
// ---------------------------------------------------------------------------
package gbd_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int M_TUSER_W  = 2;

    localparam int GBD_QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHORD_HOLD = 2'd2;

    localparam logic [CFG_W-1:0] SHORT_MIN_RESET  = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd650;
    localparam logic [CFG_W-1:0] CHORD_HOLD_RESET = 16'd2000;

    typedef enum logic [1:0] {
        ID_LEFT  = 2'd0,
        ID_RIGHT = 2'd1,
        ID_BOTH  = 2'd2
    } button_id_t;

    typedef enum logic [1:0] {
        GEST_SHORT = 2'd0,
        GEST_LONG  = 2'd1,
        GEST_CHORD = 2'd2
    } gesture_t;

    typedef struct packed {
        button_id_t button_id;
        gesture_t   gesture;
    } event_t;

    // One queue entry holds every result of one sample.
    typedef struct packed {
        logic   two;
        event_t ev0;
        event_t ev1;
    } entry_t;

endpackage

// ----- hw/rtl/two_button_gesture_detector_core.sv -----
// ---------------------------------------------------------------------------
// Two-button gesture detector
// Reports short presses, long presses and the two-button system chord from
// a stream of button samples.
// ---------------------------------------------------------------------------
// Each sample on the s_ channel carries both button levels and a millisecond
// timestamp; the block accepts one sample per clock while the queue has room.
// A sample causes zero, one or two events on the m_ channel, with m_tlast
// marking the last event of a sample. Events pass through the queue and then
// the output register. The queue has QUEUE_DEPTH entries; a sample with
// two events needs two output transfers, so the output port sets the sustained
// rate when most samples produce two events. When the receiver holds m_tready
// low the queue fills and s_tready drops once it is full; samples that
// produce no event still need a free entry to be accepted.
// The cfg channel writes the three hold times and is always ready; write it
// only while no sample is in flight. Reset clears all button state, empties
// the queue and loads the default hold times of 30, 650 and 2000 ms.
// ---------------------------------------------------------------------------
module two_button_gesture_detector_core
    import gbd_pkg::*;
#(
    parameter int QUEUE_DEPTH = GBD_QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // left_pressed, right_pressed, time_ms
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // button_id
    output logic [M_TUSER_W-1:0] m_tuser,   // gesture
    output logic                 m_tlast
);

    logic   q_push, q_full, q_pop, q_empty;
    entry_t q_entry, q_head;

    gbd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    gbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    gbd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hw/rtl/gbd_front.sv -----
// ---------------------------------------------------------------------------
// Gesture detector front end
// Holds the configuration and button state, accepts samples and turns each
// one into a queue entry with its ordered events.
// ---------------------------------------------------------------------------
module gbd_front
    import gbd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 q_full,
    output logic                 q_push,
    output entry_t               q_entry
);

    typedef struct packed {
        logic              held;
        logic              long_done;
        logic [TIME_W-1:0] press_time;
        logic              fire;
        gesture_t          gesture;
    } btn_t;

    function automatic btn_t btn_step(
        input logic              held,
        input logic              long_done,
        input logic [TIME_W-1:0] press_time,
        input logic              down,
        input logic              peer_down,
        input logic [TIME_W-1:0] now,
        input logic              chord,
        input logic [CFG_W-1:0]  short_min,
        input logic [CFG_W-1:0]  long_min
    );
        btn_t              r;
        logic [TIME_W-1:0] dur;
        dur          = now - press_time;
        r.held       = held;
        r.long_done  = long_done;
        r.press_time = press_time;
        r.fire       = 1'b0;
        r.gesture    = GEST_SHORT;
        if (down && !held) begin
            r.held       = 1'b1;
            r.long_done  = 1'b0;
            r.press_time = now;
        end else if (!down && held) begin
            r.fire      = !chord && !long_done &&
                          (dur >= {{(TIME_W-CFG_W){1'b0}}, short_min});
            r.held      = 1'b0;
            r.long_done = 1'b0;
        end else if (down && !peer_down && !long_done &&
                     (dur >= {{(TIME_W-CFG_W){1'b0}}, long_min})) begin
            r.long_done = 1'b1;
            r.fire      = 1'b1;
            r.gesture   = GEST_LONG;
        end
        return r;
    endfunction

    logic [CFG_W-1:0]  short_min_reg, long_press_reg, chord_hold_reg;
    logic              left_held_reg, left_long_reg;
    logic              right_held_reg, right_long_reg;
    logic [TIME_W-1:0] left_time_reg, right_time_reg;
    logic              chord_on_reg, chord_on_next;
    logic [TIME_W-1:0] chord_start_reg, chord_start_next;

    logic              left, right, chord_fire, accept;
    logic [TIME_W-1:0] now;
    btn_t              lb, rb;

    assign left      = s_tdata[0];
    assign right     = s_tdata[1];
    assign now       = s_tdata[TIME_W+1:2];
    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        chord_on_next    = chord_on_reg;
        chord_start_next = chord_start_reg;
        chord_fire       = 1'b0;
        if (left && right) begin
            if (!chord_on_reg && chord_start_reg == '0) begin
                chord_start_next = now;
            end
            if (!chord_on_reg &&
                (now - chord_start_next) >= {{(TIME_W-CFG_W){1'b0}}, chord_hold_reg}) begin
                chord_on_next = 1'b1;
                chord_fire    = 1'b1;
            end
        end else begin
            if (!left && !right) begin
                chord_on_next = 1'b0;
            end
            chord_start_next = '0;
        end
    end

    assign lb = btn_step(left_held_reg, left_long_reg, left_time_reg, left, right, now,
                         chord_on_next, short_min_reg, long_press_reg);
    assign rb = btn_step(right_held_reg, right_long_reg, right_time_reg, right, left, now,
                         chord_on_next, short_min_reg, long_press_reg);

    always_comb begin
        q_entry.two           = lb.fire && rb.fire;
        q_entry.ev1.button_id = ID_RIGHT;
        q_entry.ev1.gesture   = rb.gesture;
        priority if (chord_fire) begin
            q_entry.ev0.button_id = ID_BOTH;
            q_entry.ev0.gesture   = GEST_CHORD;
        end else if (lb.fire) begin
            q_entry.ev0.button_id = ID_LEFT;
            q_entry.ev0.gesture   = lb.gesture;
        end else begin
            q_entry.ev0.button_id = ID_RIGHT;
            q_entry.ev0.gesture   = rb.gesture;
        end
    end

    assign q_push = accept && (chord_fire || lb.fire || rb.fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_min_reg  <= SHORT_MIN_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            chord_hold_reg <= CHORD_HOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SHORT_MIN:  short_min_reg  <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                REG_CHORD_HOLD: chord_hold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_held_reg   <= 1'b0;
            left_long_reg   <= 1'b0;
            left_time_reg   <= '0;
            right_held_reg  <= 1'b0;
            right_long_reg  <= 1'b0;
            right_time_reg  <= '0;
            chord_on_reg    <= 1'b0;
            chord_start_reg <= '0;
        end else if (accept) begin
            left_held_reg   <= lb.held;
            left_long_reg   <= lb.long_done;
            left_time_reg   <= lb.press_time;
            right_held_reg  <= rb.held;
            right_long_reg  <= rb.long_done;
            right_time_reg  <= rb.press_time;
            chord_on_reg    <= chord_on_next;
            chord_start_reg <= chord_start_next;
        end
    end

endmodule

// ----- hw/rtl/gbd_queue.sv -----
// ---------------------------------------------------------------------------
// Gesture detector event queue
// Small first-in first-out store of event entries between front and back.
// ---------------------------------------------------------------------------
module gbd_queue
    import gbd_pkg::*;
#(
    parameter int DEPTH = GBD_QUEUE_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/gbd_back.sv -----
// ---------------------------------------------------------------------------
// Gesture detector back end
// Unpacks queue entries into single events and holds them in the output
// register until the receiver takes them.
// ---------------------------------------------------------------------------
module gbd_back
    import gbd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  entry_t               head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    logic       valid_reg, valid_next;
    logic       second_reg, second_next;
    event_t     ev_reg, ev_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = !empty && (!valid_reg || m_tready);

    always_comb begin
        valid_next  = valid_reg && !m_tready;
        second_next = second_reg;
        ev_next     = ev_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (head.two && !second_reg) begin
                ev_next     = head.ev0;
                last_next   = 1'b0;
                second_next = 1'b1;
            end else if (head.two) begin
                ev_next     = head.ev1;
                last_next   = 1'b1;
                second_next = 1'b0;
                pop         = 1'b1;
            end else begin
                ev_next   = head.ev0;
                last_next = 1'b1;
                pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_reg   <= ev_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, ev_reg.button_id};
    assign m_tuser  = ev_reg.gesture;
    assign m_tlast  = last_reg;

endmodule

// ----- hw/rtl/gbd_checker.sv -----
// ---------------------------------------------------------------------------
// Gesture detector port checker
// Checks event ordering and coding as seen on the top level's ports.
// ---------------------------------------------------------------------------
module gbd_checker
    import gbd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_chord_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == GEST_CHORD |-> m_tdata[1:0] == ID_BOTH && m_tlast)
        else $error("chord event with wrong source or not last");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[1:0] == ID_LEFT)
        else $error("first of two events is not from the left button");

    a_pair_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tlast && m_tdata[1:0] == ID_RIGHT)
        else $error("second event of a pair did not follow at once");

endmodule

bind two_button_gesture_detector_core gbd_checker u_gbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/tb_two_button_gesture_detector_core.sv -----
// ---------------------------------------------------------------------------
// Two-button gesture detector testbench
// Streams button samples into the detector and predicts every short press,
// long press and system chord that each sample should cause. Observed events
// are matched in order against the predictions. The run covers directed
// corner cases and random press timelines under several hold-time settings,
// with random idling on both sides and a long stall on the event side.
// ---------------------------------------------------------------------------
module tb_two_button_gesture_detector_core
    import gbd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int BTN_LEFT      = 0;
    localparam int BTN_RIGHT     = 1;

    typedef struct packed {
        logic        left;
        logic        right;
        logic [31:0] stamp;
    } sample_t;

    typedef struct packed {
        button_id_t id;
        gesture_t   kind;
        logic       last_flag;
    } gesture_rec_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    two_button_gesture_detector_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sample_t      samples_to_send[$];
    gesture_rec_t pending_gestures[$];
    sample_t      cur_sample;

    logic [CFG_W-1:0] min_short_hold = SHORT_MIN_RESET;
    logic [CFG_W-1:0] long_hold      = LONG_PRESS_RESET;
    logic [CFG_W-1:0] chord_hold     = CHORD_HOLD_RESET;

    logic        btn_down[2]      = '{1'b0, 1'b0};
    logic        btn_long_seen[2] = '{1'b0, 1'b0};
    logic [31:0] btn_t0[2]        = '{32'd0, 32'd0};
    logic        chord_latched    = 1'b0;
    logic [31:0] chord_t0         = 32'd0;

    int items_queued   = 0;
    int items_accepted = 0;
    int events_seen    = 0;
    int shorts_seen    = 0;
    int longs_seen     = 0;
    int chords_seen    = 0;
    int cfg_writes     = 0;
    int errors         = 0;
    int cycle_count    = 0;
    int src_idle_max   = 0;
    int sink_idle_max  = 0;
    int src_wait       = 0;
    int sink_wait      = 0;
    int hold_left      = 0;
    logic hold_start   = 1'b0;

    logic        gen_left  = 1'b0;
    logic        gen_right = 1'b0;
    logic [31:0] gen_stamp = 32'd0;

    task automatic predict_gestures(input sample_t smp);
        gesture_rec_t found[$];
        gesture_rec_t rec;
        logic [31:0]  span;
        logic         down;
        logic         other;
        for (int b = BTN_LEFT; b <= BTN_RIGHT; b++) begin
            if (b == BTN_LEFT) begin
                if (smp.left && smp.right) begin
                    if (!chord_latched && chord_t0 == 32'd0) chord_t0 = smp.stamp;
                    span = smp.stamp - chord_t0;
                    if (!chord_latched && span >= {16'd0, chord_hold}) begin
                        chord_latched = 1'b1;
                        rec = '{ID_BOTH, GEST_CHORD, 1'b0};
                        found.push_back(rec);
                    end
                end else begin
                    if (!smp.left && !smp.right) chord_latched = 1'b0;
                    chord_t0 = 32'd0;
                end
            end
            down  = (b == BTN_LEFT) ? smp.left : smp.right;
            other = (b == BTN_LEFT) ? smp.right : smp.left;
            span  = smp.stamp - btn_t0[b];
            rec.id        = (b == BTN_LEFT) ? ID_LEFT : ID_RIGHT;
            rec.last_flag = 1'b0;
            if (down && !btn_down[b]) begin
                btn_down[b]      = 1'b1;
                btn_long_seen[b] = 1'b0;
                btn_t0[b]        = smp.stamp;
            end else if (!down && btn_down[b]) begin
                if (!chord_latched && !btn_long_seen[b] && span >= {16'd0, min_short_hold}) begin
                    rec.kind = GEST_SHORT;
                    found.push_back(rec);
                end
                btn_down[b]      = 1'b0;
                btn_long_seen[b] = 1'b0;
            end else if (down && !other && !btn_long_seen[b] && span >= {16'd0, long_hold}) begin
                btn_long_seen[b] = 1'b1;
                rec.kind = GEST_LONG;
                found.push_back(rec);
            end
        end
        if (found.size() > 0) found[found.size() - 1].last_flag = 1'b1;
        foreach (found[i]) pending_gestures.push_back(found[i]);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_gestures(cur_sample);
                items_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end else if (samples_to_send.size() > 0) begin
                    cur_sample = samples_to_send.pop_front();
                    s_tdata    <= {{(S_TDATA_W - 34){1'b0}}, cur_sample.stamp,
                                   cur_sample.right, cur_sample.left};
                    s_tvalid   <= 1'b1;
                    src_wait   = $urandom_range(0, src_idle_max);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        gesture_rec_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                events_seen++;
                case (gesture_t'(m_tuser))
                    GEST_SHORT: shorts_seen++;
                    GEST_LONG:  longs_seen++;
                    GEST_CHORD: chords_seen++;
                    default: ;
                endcase
                if (pending_gestures.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected event: expected none, got id %0d gesture %0d last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = pending_gestures.pop_front();
                    if (m_tdata !== {{(M_TDATA_W - 2){1'b0}}, want.id}
                            || m_tuser !== want.kind || m_tlast !== want.last_flag) begin
                        errors++;
                        $display({"%0t: event mismatch: expected id %0d gesture %0d last %0b, ",
                                  "got id %0d gesture %0d last %0b"},
                                 $time, want.id, want.kind, want.last_flag,
                                 m_tdata, m_tuser, m_tlast);
                    end
                end
                sink_wait = $urandom_range(0, sink_idle_max);
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d events still expected", $time,
                     pending_gestures.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SHORT_MIN:  min_short_hold = val;
            REG_LONG_PRESS: long_hold      = val;
            REG_CHORD_HOLD: chord_hold     = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_holds(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] l,
                             input logic [CFG_W-1:0] c);
        write_reg(REG_SHORT_MIN, s);
        write_reg(REG_LONG_PRESS, l);
        write_reg(REG_CHORD_HOLD, c);
    endtask

    task automatic add_sample(input logic l, input logic r, input logic [31:0] t);
        sample_t smp;
        smp = '{l, r, t};
        samples_to_send.push_back(smp);
        items_queued++;
    endtask

    task automatic add_random(input int count, input int step_max);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                gen_left  = 1'($urandom_range(0, 1));
                gen_right = 1'($urandom_range(0, 1));
                add_sample(gen_left, gen_right, $urandom);
            end else begin
                if ($urandom_range(0, 3) == 0) gen_left = !gen_left;
                if ($urandom_range(0, 3) == 0) gen_right = !gen_right;
                if ($urandom_range(0, 19) == 0)
                    gen_stamp += $urandom_range(0, 4 * step_max);
                else
                    gen_stamp += $urandom_range(0, step_max);
                add_sample(gen_left, gen_right, gen_stamp);
            end
        end
    endtask

    task automatic wait_idle();
        while (items_accepted != items_queued || pending_gestures.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        src_idle_max  = 14;
        sink_idle_max = 14;
        add_sample(1'b1, 1'b1, 32'd0);
        add_sample(1'b1, 1'b1, 32'd100);
        add_sample(1'b1, 1'b1, 32'd2100);
        add_sample(1'b0, 1'b1, 32'd2200);
        add_sample(1'b0, 1'b1, 32'd3000);
        add_sample(1'b0, 1'b0, 32'd3100);
        add_sample(1'b1, 1'b0, 32'd4000);
        add_sample(1'b0, 1'b0, 32'd4010);
        add_sample(1'b1, 1'b0, 32'd4100);
        add_sample(1'b0, 1'b0, 32'd4130);
        add_sample(1'b0, 1'b1, 32'd5000);
        add_sample(1'b0, 1'b1, 32'd5649);
        add_sample(1'b0, 1'b1, 32'd5650);
        add_sample(1'b0, 1'b0, 32'd5700);
        add_sample(1'b1, 1'b0, 32'd6000);
        add_sample(1'b1, 1'b1, 32'd6001);
        add_sample(1'b0, 1'b0, 32'd6100);
        add_sample(1'b0, 1'b1, 32'd8000);
        add_sample(1'b1, 1'b1, 32'd8640);
        add_sample(1'b0, 1'b1, 32'd8700);
        add_sample(1'b0, 1'b0, 32'd8800);
        add_sample(1'b1, 1'b0, 32'hFFFF_FF00);
        add_sample(1'b0, 1'b0, 32'h0000_0100);
        add_sample(1'b1, 1'b1, 32'hFFFF_FFFF);
        add_sample(1'b0, 1'b0, 32'hFFFF_FFFF);
        wait_idle();

        set_holds(16'd5, 16'd40, 16'd100);
        write_reg(REG_UNUSED, 16'hFFFF);
        src_idle_max  = 0;
        sink_idle_max = 0;
        add_random(150, 30);
        wait_idle();
        src_idle_max  = 14;
        sink_idle_max = 14;
        add_random(150, 30);
        wait_idle();

        set_holds(16'd0, 16'd0, 16'd0);
        src_idle_max  = 14;
        sink_idle_max = 3;
        add_random(150, 5);
        wait_idle();

        set_holds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        gen_stamp     = 32'hFFF0_0000;
        src_idle_max  = 3;
        sink_idle_max = 14;
        add_random(150, 20000);
        wait_idle();

        set_holds(CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 300)),
                  CFG_W'($urandom_range(0, 300)));
        src_idle_max  = 0;
        sink_idle_max = 14;
        add_random(100, 80);
        @(posedge aclk);
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        wait_idle();
        set_holds(CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 300)),
                  CFG_W'($urandom_range(0, 300)));
        src_idle_max  = 14;
        sink_idle_max = 0;
        add_random(200, 80);
        wait_idle();

        set_holds(SHORT_MIN_RESET, LONG_PRESS_RESET, CHORD_HOLD_RESET);
        src_idle_max  = 14;
        sink_idle_max = 14;
        add_random(130, 400);
        wait_idle();

        $display("Sent %0d samples over %0d register writes and several hold-time settings.",
                 items_accepted, cfg_writes);
        $display("Checked %0d events: %0d short, %0d long, %0d chord; %0d errors.",
                 events_seen, shorts_seen, longs_seen, chords_seen, errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
